>>> rtl/hcbp_pkg.sv
`default_nettype none

package hcbp_pkg;

    localparam int SYM_BITS       = 8;
    localparam int LEN_BITS       = 7;
    localparam int ACT_BITS       = 2;
    localparam int TABLE_DEPTH    = 256;
    localparam int OUT_BITS       = 64;
    localparam int SHIFT_BITS     = 8;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;
    localparam int S_TDATA_BITS   = 80;

    localparam logic [SYM_BITS-1:0] END_SYMBOL   = 8'd0;
    localparam logic [SYM_BITS-1:0] ESCAPE_RESET = 8'd92;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FINISH = 2'd2
    } action_t;

    typedef struct packed {
        logic valid;
        logic flush;
    } pack_op_t;

    typedef struct packed {
        logic                last;
        logic [OUT_BITS-1:0] word;
    } out_item_t;

endpackage

`default_nettype wire

>>> rtl/hcbp_code_table.sv
`default_nettype none

module hcbp_code_table #(
    parameter int DATA_BITS = 71
) (
    input  wire logic                            aclk,
    input  wire logic                            en,
    input  wire logic                            we,
    input  wire logic [hcbp_pkg::SYM_BITS-1:0]   addr,
    input  wire logic [DATA_BITS-1:0]            wdata,
    output      logic [DATA_BITS-1:0]            rdata
);

    logic [DATA_BITS-1:0] mem [hcbp_pkg::TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/hcbp_packer.sv
`default_nettype none

module hcbp_packer #(
    parameter int WORD_BITS = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire hcbp_pkg::pack_op_t              op,
    input  wire logic [hcbp_pkg::LEN_BITS-1:0]   rd_len,
    input  wire logic [WORD_BITS-1:0]            rd_code,
    output      logic                            push_valid,
    output      hcbp_pkg::out_item_t             push_item
);

    localparam int FILL_BITS = $clog2(WORD_BITS + 1);
    localparam int SB        = hcbp_pkg::SHIFT_BITS;

    logic [WORD_BITS-1:0]   buf_reg, buf_next;
    logic [FILL_BITS-1:0]   fill_reg, fill_next;

    logic [2*WORD_BITS-1:0] cat_w;
    logic [SB-1:0]          total;
    logic [SB-1:0]          over;
    logic [WORD_BITS-1:0]   word;
    logic [WORD_BITS-1:0]   ones;

    always_comb begin
        ones       = {WORD_BITS{1'b1}};
        cat_w      = ({{WORD_BITS{1'b0}}, buf_reg} << rd_len)
                   | {{WORD_BITS{1'b0}}, rd_code};
        total      = SB'(fill_reg) + SB'(rd_len);
        over       = total - SB'(WORD_BITS);
        word       = '0;
        buf_next   = buf_reg;
        fill_next  = fill_reg;
        push_valid = 1'b0;
        push_item  = '0;
        if (op.valid) begin
            if (op.flush) begin
                word       = buf_reg << (SB'(WORD_BITS) - SB'(fill_reg));
                buf_next   = '0;
                fill_next  = '0;
                push_valid = 1'b1;
                push_item.last = 1'b1;
            end else if (total >= SB'(WORD_BITS)) begin
                word       = WORD_BITS'(cat_w >> over);
                buf_next   = cat_w[WORD_BITS-1:0] & (ones >> (SB'(WORD_BITS) - over));
                fill_next  = FILL_BITS'(over);
                push_valid = 1'b1;
            end else begin
                buf_next   = cat_w[WORD_BITS-1:0];
                fill_next  = FILL_BITS'(total);
            end
        end
        push_item.word = hcbp_pkg::OUT_BITS'(word);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg  <= '0;
            fill_reg <= '0;
        end else begin
            buf_reg  <= buf_next;
            fill_reg <= fill_next;
        end
    end

`ifndef SYNTHESIS
    a_fill_below_word: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < FILL_BITS'(WORD_BITS))
        else $error("packer fill reached a full word");
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (op.valid && op.flush) |=> (fill_reg == '0 && buf_reg == '0))
        else $error("buffer not empty after flush");
    a_flush_emits_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (op.valid && op.flush) |-> (push_valid && push_item.last))
        else $error("flush without last word");
`endif

endmodule

`default_nettype wire

>>> rtl/hcbp_out_queue.sv
`default_nettype none

module hcbp_out_queue (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  push_valid,
    input  wire hcbp_pkg::out_item_t                   push_item,
    input  wire logic                                  pop,
    output      logic                                  head_valid,
    output      hcbp_pkg::out_item_t                   head_item,
    output      logic [hcbp_pkg::QUEUE_CNT_BITS-1:0]   count
);

    localparam int PB = hcbp_pkg::QUEUE_PTR_BITS;
    localparam int CB = hcbp_pkg::QUEUE_CNT_BITS;

    hcbp_pkg::out_item_t entries [hcbp_pkg::QUEUE_DEPTH];

    logic [PB-1:0] head_reg, head_next;
    logic [PB-1:0] tail_reg, tail_next;
    logic [CB-1:0] count_reg, count_next;
    logic          do_pop;

    always_comb begin
        do_pop     = pop && (count_reg != '0);
        head_next  = do_pop ? head_reg + PB'(1) : head_reg;
        tail_next  = push_valid ? tail_reg + PB'(1) : tail_reg;
        count_next = count_reg + CB'(push_valid) - CB'(do_pop);
        head_valid = (count_reg != '0);
        head_item  = entries[head_reg];
        count      = count_reg;
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            entries[tail_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == CB'(hcbp_pkg::QUEUE_DEPTH)) |-> !push_valid)
        else $error("word pushed into full queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CB'(hcbp_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
    a_push_to_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 && push_valid) |=> head_valid)
        else $error("pushed word not visible");
`endif

endmodule

`default_nettype wire

>>> rtl/huffman_code_bit_packer.sv
// path: item register, then table read and op register, then packer into the output queue
// throughput: one item per cycle for loads, and for plain bytes while the queue has room; an escaped
// byte takes two steps (escape lookup, symbol lookup) and a finish two (END lookup, then flush)
// output words wait in a 4-word queue; issue holds while the queue could overflow
// reset: synchronous active-low aresetn empties the bit buffer and queue, sets escape to 92
// reset leaves the code table contents undefined until loaded
`default_nettype none

module huffman_code_bit_packer #(
    parameter int WORD_BITS = 64
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic [7:0]    cfg_wdata,
    input  wire logic          s_axis_tvalid,
    output      logic          s_axis_tready,
    input  wire logic [79:0]   s_axis_tdata,   // symbol, code_length, code_bits, zero pad
    input  wire logic [1:0]    s_axis_tuser,   // action
    output      logic          m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output      logic [63:0]   m_axis_tdata,   // out_word
    output      logic          m_axis_tlast    // last_word
);

    localparam int SYB = hcbp_pkg::SYM_BITS;
    localparam int LB  = hcbp_pkg::LEN_BITS;
    localparam int SB  = hcbp_pkg::SHIFT_BITS;
    localparam int CB  = hcbp_pkg::QUEUE_CNT_BITS;
    localparam int DB  = LB + WORD_BITS;

    logic [SYB-1:0]       esc_reg;

    logic                 item_valid_reg, item_valid_next;
    logic [1:0]           item_act_reg, item_act_next;
    logic [SYB-1:0]       item_sym_reg, item_sym_next;
    logic [LB-1:0]        item_len_reg, item_len_next;
    logic [WORD_BITS-1:0] item_code_reg, item_code_next;
    logic                 item_step_reg, item_step_next;

    hcbp_pkg::pack_op_t   op_reg, op_next;

    logic                 accept;
    logic                 done;
    logic                 space_ok;
    logic                 need_esc;
    logic                 mem_en, mem_we;
    logic [SYB-1:0]       mem_addr;
    logic [DB-1:0]        mem_rdata;
    logic [LB-1:0]        len_in, len_sat;
    logic [WORD_BITS-1:0] code_mask;

    logic                 push_valid;
    hcbp_pkg::out_item_t  push_item;
    hcbp_pkg::out_item_t  head_item;
    logic [CB-1:0]        q_count;

    always_comb begin
        len_in    = s_axis_tdata[14:8];
        len_sat   = (len_in > LB'(WORD_BITS)) ? LB'(WORD_BITS) : len_in;
        code_mask = {WORD_BITS{1'b1}} >> (SB'(WORD_BITS) - SB'(len_sat));
    end

    always_comb begin
        space_ok = ((CB + 1)'(q_count) + (CB + 1)'(op_reg.valid))
                 < (CB + 1)'(hcbp_pkg::QUEUE_DEPTH);
        need_esc = (item_sym_reg == hcbp_pkg::END_SYMBOL) || (item_sym_reg == esc_reg);
        mem_en   = 1'b0;
        mem_we   = 1'b0;
        mem_addr = item_sym_reg;
        op_next  = '0;
        done     = 1'b0;
        item_step_next = item_step_reg;
        if (item_valid_reg) begin
            case (item_act_reg)
                hcbp_pkg::ACT_LOAD: begin
                    mem_en = 1'b1;
                    mem_we = 1'b1;
                    done   = 1'b1;
                end
                hcbp_pkg::ACT_ENCODE: begin
                    if (space_ok) begin
                        mem_en        = 1'b1;
                        op_next.valid = 1'b1;
                        if (!item_step_reg && need_esc) begin
                            mem_addr       = esc_reg;
                            item_step_next = 1'b1;
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
                hcbp_pkg::ACT_FINISH: begin
                    if (space_ok) begin
                        op_next.valid = 1'b1;
                        if (!item_step_reg) begin
                            mem_en         = 1'b1;
                            mem_addr       = hcbp_pkg::END_SYMBOL;
                            item_step_next = 1'b1;
                        end else begin
                            op_next.flush = 1'b1;
                            done          = 1'b1;
                        end
                    end
                end
                default: begin
                    done = 1'b1;
                end
            endcase
        end
        s_axis_tready = !item_valid_reg || done;
        accept        = s_axis_tvalid && s_axis_tready;
    end

    always_comb begin
        item_valid_next = item_valid_reg;
        item_act_next   = item_act_reg;
        item_sym_next   = item_sym_reg;
        item_len_next   = item_len_reg;
        item_code_next  = item_code_reg;
        if (accept) begin
            item_valid_next = 1'b1;
            item_act_next   = s_axis_tuser;
            item_sym_next   = s_axis_tdata[7:0];
            item_len_next   = len_sat;
            item_code_next  = s_axis_tdata[15 +: WORD_BITS] & code_mask;
        end else if (done) begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg        <= hcbp_pkg::ESCAPE_RESET;
            item_valid_reg <= 1'b0;
            item_step_reg  <= 1'b0;
            op_reg         <= '0;
        end else begin
            if (cfg_we) begin
                esc_reg <= cfg_wdata;
            end
            item_valid_reg <= item_valid_next;
            item_step_reg  <= accept ? 1'b0 : item_step_next;
            op_reg         <= op_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_act_reg  <= item_act_next;
        item_sym_reg  <= item_sym_next;
        item_len_reg  <= item_len_next;
        item_code_reg <= item_code_next;
    end

    hcbp_code_table #(
        .DATA_BITS (DB)
    ) u_table (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata ({item_len_reg, item_code_reg}),
        .rdata (mem_rdata)
    );

    hcbp_packer #(
        .WORD_BITS (WORD_BITS)
    ) u_packer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (op_reg),
        .rd_len     (mem_rdata[DB-1 -: LB]),
        .rd_code    (mem_rdata[WORD_BITS-1:0]),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    hcbp_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .pop        (m_axis_tready),
        .head_valid (m_axis_tvalid),
        .head_item  (head_item),
        .count      (q_count)
    );

    assign m_axis_tdata = head_item.word;
    assign m_axis_tlast = head_item.last;

`ifndef SYNTHESIS
    a_load_takes_port: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (mem_en && !op_next.valid))
        else $error("table write overlaps a lookup");
    a_escape_then_symbol: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid_reg && item_step_reg && item_act_reg == hcbp_pkg::ACT_ENCODE)
        |-> (mem_addr == item_sym_reg))
        else $error("second lookup of escaped byte misaddressed");
    a_flush_without_read: assert property (@(posedge aclk) disable iff (!aresetn)
        op_next.flush |-> !mem_en)
        else $error("flush issued with a table access");
`endif

endmodule

`default_nettype wire
